/* src/acestm_pkg.sv */
// Shared constants, types and the code threshold table for the tone map and sRGB encoder.
`timescale 1ns / 1ps

package acestm_pkg;

   localparam int INPUT_FRAC_BITS = 16;
   localparam int IN_W = 32;
   localparam int X_W = INPUT_FRAC_BITS + 3;
   localparam int N_W = 2 * INPUT_FRAC_BITS + 14;
   localparam int Y_FRAC = 24;
   localparam int Y_W = Y_FRAC + 1;
   localparam int CODE_W = 8;
   localparam int CODE_N = 256;
   localparam int LIN_TOP_CODE = 10;

   localparam int TONE_ST = 3;
   localparam int DIV_ST = Y_FRAC;
   localparam int ENC_ST = CODE_W;
   localparam int LANE_ST = TONE_ST + DIV_ST + ENC_ST;
   localparam int NUM_ST = LANE_ST + 1;

   typedef logic [Y_W-1:0] thr_arr_type [CODE_N];

   localparam int BIG_W = 320;

   function automatic logic thr_reaches(input logic [Y_W-1:0] y, input int k);
      logic [BIG_W-1:0] a;
      logic [BIG_W-1:0] b;
      logic             res;
      a = '0;
      b = '0;
      if (k <= LIN_TOP_CODE) begin
         a = BIG_W'(y) * BIG_W'(65892);
         b = (BIG_W'(2 * k - 1) * BIG_W'(10)) << Y_FRAC;
         res = (a >= b);
      end else begin
         a = BIG_W'(1);
         b = BIG_W'(1);
         for (int i = 0; i < 5; i++) begin
            a = a * BIG_W'(y);
            b = b << Y_FRAC;
         end
         for (int i = 0; i < 12; i++) begin
            a = a * BIG_W'(10761);
            b = b * BIG_W'(40 * k + 541);
         end
         res = (a >= b);
      end
      return res;
   endfunction

   function automatic thr_arr_type build_thresholds();
      thr_arr_type      t;
      logic [Y_W:0]     lo;
      logic [Y_W:0]     hi;
      logic [Y_W:0]     mid;
      t[0] = '0;
      for (int k = 1; k < CODE_N; k++) begin
         lo = '0;
         hi = (Y_W+1)'(1) << Y_FRAC;
         for (int i = 0; i < Y_W + 1; i++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               if (thr_reaches(mid[Y_W-1:0], k)) begin
                  hi = mid;
               end else begin
                  lo = mid + 1'b1;
               end
            end
         end
         t[k] = lo[Y_W-1:0];
      end
      return t;
   endfunction

   localparam thr_arr_type THRESH = build_thresholds();

endpackage

/* src/acestm_tone.sv */
// Tone curve front end: input classification and numerator/denominator products.
`timescale 1ns / 1ps

module acestm_tone
   import acestm_pkg::*;
(
   input  logic                  clock,
   input  logic [TONE_ST-1:0]    en,
   input  logic signed [IN_W-1:0] x_in,
   output logic [N_W-1:0]        num_out,
   output logic [N_W-1:0]        den_out,
   output logic                  zero_out,
   output logic                  sat_out
);

   localparam logic signed [IN_W-1:0] SAT_LIM = IN_W'(8) <<< INPUT_FRAC_BITS;
   localparam logic [N_W-1:0] ONE = N_W'(1) << INPUT_FRAC_BITS;

   logic [X_W-1:0] x_ff;
   logic           zero1_ff, sat1_ff;
   logic [N_W-1:0] num2_ff, den2_ff, num2_in, den2_in;
   logic           zero2_ff, sat2_ff;
   logic [N_W-1:0] num3_ff, den3_ff;
   logic           zero3_ff, sat3_ff;

   always_comb begin
      num2_in = N_W'(x_ff) * (N_W'(x_ff) * N_W'(251) + N_W'(3) * ONE);
      den2_in = N_W'(x_ff) * (N_W'(x_ff) * N_W'(243) + N_W'(59) * ONE)
                + ((N_W'(14) * ONE) << INPUT_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff     <= x_in[X_W-1:0];
         zero1_ff <= (x_in <= 0);
         sat1_ff  <= (x_in >= SAT_LIM);
      end
      if (en[1]) begin
         num2_ff  <= num2_in;
         den2_ff  <= den2_in;
         zero2_ff <= zero1_ff;
         sat2_ff  <= sat1_ff;
      end
      if (en[2]) begin
         num3_ff  <= num2_ff;
         den3_ff  <= den2_ff;
         zero3_ff <= zero2_ff;
         sat3_ff  <= sat2_ff || (num2_ff >= den2_ff);
      end
   end

   assign num_out  = num3_ff;
   assign den_out  = den3_ff;
   assign zero_out = zero3_ff;
   assign sat_out  = sat3_ff;

endmodule

/* src/acestm_div.sv */
// Pipelined restoring divider giving the curve value as Q1.24, one quotient bit per stage.
`timescale 1ns / 1ps

module acestm_div
   import acestm_pkg::*;
(
   input  logic               clock,
   input  logic [DIV_ST-1:0]  en,
   input  logic [N_W-1:0]     num_in,
   input  logic [N_W-1:0]     den_in,
   input  logic               zero_in,
   input  logic               sat_in,
   output logic [Y_W-1:0]     y_out
);

   logic [N_W-1:0]    rem_ff  [DIV_ST];
   logic [N_W-1:0]    den_ff  [DIV_ST];
   logic [Y_FRAC-1:0] quo_ff  [DIV_ST];
   logic              zero_ff [DIV_ST];
   logic              sat_ff  [DIV_ST];

   for (genvar s = 0; s < DIV_ST; s++) begin : g_stage
      logic [N_W-1:0]    rem_prev, den_prev;
      logic [Y_FRAC-1:0] quo_prev;
      logic              zero_prev, sat_prev;
      logic [N_W:0]      rem_sh;
      logic              take;

      if (s == 0) begin : g_first
         assign rem_prev  = num_in;
         assign den_prev  = den_in;
         assign quo_prev  = '0;
         assign zero_prev = zero_in;
         assign sat_prev  = sat_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign quo_prev  = quo_ff[s-1];
         assign zero_prev = zero_ff[s-1];
         assign sat_prev  = sat_ff[s-1];
      end

      assign rem_sh = {rem_prev, 1'b0};
      assign take   = (rem_sh >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s]  <= take ? N_W'(rem_sh - {1'b0, den_prev}) : rem_sh[N_W-1:0];
            den_ff[s]  <= den_prev;
            quo_ff[s]  <= {quo_prev[Y_FRAC-2:0], take};
            zero_ff[s] <= zero_prev;
            sat_ff[s]  <= sat_prev;
         end
      end
   end

   always_comb begin
      if (zero_ff[DIV_ST-1]) begin
         y_out = '0;
      end else if (sat_ff[DIV_ST-1]) begin
         y_out = Y_W'(1) << Y_FRAC;
      end else begin
         y_out = {1'b0, quo_ff[DIV_ST-1]};
      end
   end

endmodule

/* src/acestm_enc.sv */
// Pipelined binary search of the sRGB code against the linear threshold table.
`timescale 1ns / 1ps

module acestm_enc
   import acestm_pkg::*;
(
   input  logic               clock,
   input  logic [ENC_ST-1:0]  en,
   input  logic [Y_W-1:0]     y_in,
   output logic [CODE_W-1:0]  code_out
);

   logic [Y_W-1:0]    y_ff    [ENC_ST];
   logic [CODE_W-1:0] code_ff [ENC_ST];

   for (genvar s = 0; s < ENC_ST; s++) begin : g_stage
      localparam int BIT = ENC_ST - 1 - s;
      logic [Y_W-1:0]    y_prev;
      logic [CODE_W-1:0] code_prev, cand;

      if (s == 0) begin : g_first
         assign y_prev    = y_in;
         assign code_prev = '0;
      end else begin : g_next
         assign y_prev    = y_ff[s-1];
         assign code_prev = code_ff[s-1];
      end

      assign cand = code_prev | (CODE_W'(1) << BIT);

      always_ff @(posedge clock) begin
         if (en[s]) begin
            y_ff[s]    <= y_prev;
            code_ff[s] <= (y_prev >= THRESH[cand]) ? cand : code_prev;
         end
      end
   end

   assign code_out = code_ff[ENC_ST-1];

endmodule

/* src/acestm_lane.sv */
// One color channel: tone curve, divider and sRGB code search in series.
`timescale 1ns / 1ps

module acestm_lane
   import acestm_pkg::*;
(
   input  logic                   clock,
   input  logic [LANE_ST-1:0]     en,
   input  logic signed [IN_W-1:0] x_in,
   output logic [CODE_W-1:0]      code_out
);

   logic [N_W-1:0] num, den;
   logic           zero, sat;
   logic [Y_W-1:0] y;

   acestm_tone u_tone (
      .clock    (clock),
      .en       (en[TONE_ST-1:0]),
      .x_in     (x_in),
      .num_out  (num),
      .den_out  (den),
      .zero_out (zero),
      .sat_out  (sat)
   );

   acestm_div u_div (
      .clock   (clock),
      .en      (en[TONE_ST+DIV_ST-1:TONE_ST]),
      .num_in  (num),
      .den_in  (den),
      .zero_in (zero),
      .sat_in  (sat),
      .y_out   (y)
   );

   acestm_enc u_enc (
      .clock    (clock),
      .en       (en[LANE_ST-1:TONE_ST+DIV_ST]),
      .y_in     (y),
      .code_out (code_out)
   );

endmodule

/* src/aces_tonemap_srgb_encode.sv */
// Top level: three channel lanes, stage valid tracking and the merged output register.
`timescale 1ns / 1ps

// Filmic tone map and 8-bit sRGB encode of one signed Q15.16 RGB pixel per transaction.
// One pixel is accepted every clock unless req_stall is high. Stages: 3 curve stages, 24 divider
// stages producing one quotient bit each, 8 code search stages, 1 output register.
// Each stage holds only while its successor is occupied and stalled, so pipeline bubbles
// are squeezed out and new pixels keep entering a waiting pipeline while bubbles remain.

module aces_tonemap_srgb_encode
   import acestm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [IN_W-1:0] req_red_linear,
   input  logic signed [IN_W-1:0] req_green_linear,
   input  logic signed [IN_W-1:0] req_blue_linear,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CODE_W-1:0]      rsp_red_byte,
   output logic [CODE_W-1:0]      rsp_green_byte,
   output logic [CODE_W-1:0]      rsp_blue_byte
);

   logic [NUM_ST-1:0] valid_ff, valid_in;
   logic [NUM_ST-1:0] en;
   logic [CODE_W-1:0] red_code, green_code, blue_code;
   logic [CODE_W-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      en[NUM_ST-1] = !valid_ff[NUM_ST-1] || !rsp_stall;
      for (int i = NUM_ST - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in = valid_ff;
      if (en[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < NUM_ST; i++) begin
         if (en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   acestm_lane u_lane_red (
      .clock    (clock),
      .en       (en[LANE_ST-1:0]),
      .x_in     (req_red_linear),
      .code_out (red_code)
   );

   acestm_lane u_lane_green (
      .clock    (clock),
      .en       (en[LANE_ST-1:0]),
      .x_in     (req_green_linear),
      .code_out (green_code)
   );

   acestm_lane u_lane_blue (
      .clock    (clock),
      .en       (en[LANE_ST-1:0]),
      .x_in     (req_blue_linear),
      .code_out (blue_code)
   );

   always_ff @(posedge clock) begin
      if (en[NUM_ST-1]) begin
         red_ff   <= red_code;
         green_ff <= green_code;
         blue_ff  <= blue_code;
      end
   end

   assign req_stall      = !en[0];
   assign rsp_valid      = valid_ff[NUM_ST-1];
   assign rsp_red_byte   = red_ff;
   assign rsp_green_byte = green_ff;
   assign rsp_blue_byte  = blue_ff;

endmodule

/* sim/tb_aces_tonemap_srgb_encode.sv */
// Filmic tone map and 8-bit sRGB encoder bench: directed, random, backpressure, full rate.
`timescale 1ns / 1ps

module tb_aces_tonemap_srgb_encode;
   import acestm_pkg::*;

   typedef struct packed {
      logic [CODE_W-1:0] red;
      logic [CODE_W-1:0] green;
      logic [CODE_W-1:0] blue;
   } pixel_code_type;

   localparam int FRAC = INPUT_FRAC_BITS;
   localparam int LAT = NUM_ST + 4;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic signed [IN_W-1:0] req_red_linear;
   logic signed [IN_W-1:0] req_green_linear;
   logic signed [IN_W-1:0] req_blue_linear;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [CODE_W-1:0]      rsp_red_byte;
   logic [CODE_W-1:0]      rsp_green_byte;
   logic [CODE_W-1:0]      rsp_blue_byte;

   pixel_code_type expected_codes[$];
   int             mismatches;
   int             failures;
   int             hold_cycles;
   bit             quiet;

   aces_tonemap_srgb_encode DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_red_linear(req_red_linear),
      .req_green_linear(req_green_linear),
      .req_blue_linear(req_blue_linear),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red_byte(rsp_red_byte),
      .rsp_green_byte(rsp_green_byte),
      .rsp_blue_byte(rsp_blue_byte)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [Y_W-1:0] filmic_curve(input logic signed [IN_W-1:0] x);
      logic [63:0]  ux;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [127:0] q;
      if (x <= 0) return '0;
      if (x >= (32'sd8 <<< FRAC)) return Y_W'(1) << Y_FRAC;
      ux = 64'(x);
      num = ux * (64'd251 * ux + (64'd3 << FRAC));
      den = ux * (64'd243 * ux + (64'd59 << FRAC)) + (64'd14 << (2 * FRAC));
      if (num >= den) return Y_W'(1) << Y_FRAC;
      q = (128'(num) << Y_FRAC) / 128'(den);
      return q[Y_W-1:0];
   endfunction

   function automatic bit code_reached(input logic [Y_W-1:0] y, input int k);
      logic [319:0] lhs;
      logic [319:0] rhs;
      if (k <= LIN_TOP_CODE)
         return 64'(y) * 64'd65892 >= (64'((2 * k - 1) * 10) << Y_FRAC);
      lhs = 320'd1;
      rhs = 320'd1 << (5 * Y_FRAC);
      for (int i = 0; i < 5; i++) lhs = lhs * 320'(y);
      for (int i = 0; i < 12; i++) begin
         lhs = lhs * 320'd10761;
         rhs = rhs * 320'(40 * k + 541);
      end
      return lhs >= rhs;
   endfunction

   function automatic logic [CODE_W-1:0] srgb_code(input logic signed [IN_W-1:0] x);
      logic [Y_W-1:0]    y;
      logic [CODE_W-1:0] code;
      y = filmic_curve(x);
      code = '0;
      for (int b = CODE_W - 1; b >= 0; b--)
         if (code_reached(y, int'(code | (8'd1 << b)))) code = code | (8'd1 << b);
      return code;
   endfunction

   task automatic send_pixel(input logic [IN_W-1:0] r, input logic [IN_W-1:0] g,
                             input logic [IN_W-1:0] b);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_red_linear <= r;
      req_green_linear <= g;
      req_blue_linear <= b;
      do @(posedge clock); while (req_stall);
      expected_codes.push_back('{srgb_code(r), srgb_code(g), srgb_code(b)});
      if (quiet) gap = 0;
      else if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
      else gap = 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic [IN_W-1:0] random_radiance();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 8 << FRAC);
         2: return $urandom_range(0, 2000);
         3: return $urandom_range(0, 1 << FRAC);
         4: return $urandom_range(7 << FRAC, 9 << FRAC);
         default: return -$urandom_range(0, 1 << 20);
      endcase
   endfunction

   task automatic test_directed();
      logic [IN_W-1:0] edge_vals[$];
      edge_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'd1, 32'd2, 32'd15, 32'd40, 32'd100, 32'd1 << FRAC,
                    (32'd8 << FRAC) - 1, 32'd8 << FRAC, 32'd474480, 32'd474481,
                    32'd470000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd3000, 32'd20000};
      foreach (edge_vals[i])
         send_pixel(edge_vals[i], edge_vals[(i + 1) % edge_vals.size()],
                    edge_vals[(i + 7) % edge_vals.size()]);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_pixel(random_radiance(), random_radiance(), random_radiance());
   endtask

   task automatic test_backpressure();
      hold_cycles = 150;
      repeat (120) send_pixel(random_radiance(), random_radiance(), random_radiance());
   endtask

   task automatic test_full_rate();
      quiet = 1'b1;
      test_random(300);
      quiet = 1'b0;
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 15) == 0) hold_cycles = $urandom_range(10, 50);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_codes.size() == 0) begin
            failures++;
            $display("unexpected transaction: %0d %0d %0d",
                     rsp_red_byte, rsp_green_byte, rsp_blue_byte);
         end else begin
            automatic pixel_code_type exp_px = expected_codes.pop_front();
            if (exp_px.red !== rsp_red_byte || exp_px.green !== rsp_green_byte ||
                exp_px.blue !== rsp_blue_byte) begin
               failures++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           exp_px.red, exp_px.green, exp_px.blue,
                           rsp_red_byte, rsp_green_byte, rsp_blue_byte);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int wait_cycles;
      failures = 0;
      mismatches = 0;
      hold_cycles = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_red_linear = '0;
      req_green_linear = '0;
      req_blue_linear = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(700);
      test_backpressure();
      test_full_rate();
      test_random(630);
      @(negedge clock);
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (expected_codes.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LAT) @(posedge clock);
      if (expected_codes.size() != 0) begin
         failures++;
         $display("%0d transactions never arrived", expected_codes.size());
      end
      if (failures == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
